[src/periodic_value_noise_fbm_core_assert.svh]
// Assertion macros used by the checker file of the noise core
`ifndef PERIODIC_VALUE_NOISE_FBM_CORE_ASSERT_SVH
`define PERIODIC_VALUE_NOISE_FBM_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define PVNF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define PVNF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/pvnf_pkg.sv]
// Shared types, constants and weight functions of the value noise core
package pvnf_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COORD_BITS_DEF  = 16;

  localparam int SALT_W  = 32;
  localparam int BASE_W  = 11;
  localparam int COUNT_W = 4;
  localparam int VAL_W   = 24;
  localparam int WGT_W   = 24;
  localparam int RECIP_W = 17;
  localparam int OUT_W   = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Register indexes
  localparam logic [1:0] REG_SALT  = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  // Hash constants
  localparam logic [31:0] HASH_X   = 32'h8da6b343;
  localparam logic [31:0] HASH_Y   = 32'hd8163841;
  localparam logic [31:0] GOLDEN   = 32'h9e3779b9;
  localparam logic [31:0] SALT_OFS = 32'h68bc21eb;
  localparam logic [31:0] MIX_M1   = 32'h7feb352d;
  localparam logic [31:0] MIX_M2   = 32'h846ca68b;

  // Octave weights in Q0.24
  localparam longint unsigned W_FIRST = 64'd9395241;
  localparam longint unsigned W_RATIO = 64'd8053064;

  typedef struct packed {
    logic [SALT_W-1:0]  noise_salt;
    logic [BASE_W-1:0]  base_cells;
    logic [COUNT_W-1:0] octave_count;
  } pvnf_cfg_t;

  // Weight of octave k, each step rounded to Q0.24
  function automatic logic [WGT_W-1:0] octave_weight(int k);
    longint unsigned w;
    w = W_FIRST;
    for (int i = 0; i < k; i++) begin
      w = (w * W_RATIO + 64'h800000) >> 24;
    end
    return WGT_W'(w);
  endfunction

  // Sum of the first c octave weights
  function automatic longint unsigned total_weight(int c);
    longint unsigned t;
    t = 64'd0;
    for (int i = 0; i < c; i++) begin
      t = t + 64'(octave_weight(i));
    end
    return t;
  endfunction

endpackage

[src/pvnf_apb_regs.sv]
// APB register file holding salt, base cell count and octave count
module pvnf_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pvnf_pkg::ADDR_W-1:0]     paddr,
  input  logic [pvnf_pkg::DATA_W-1:0]     pwdata,
  output logic [pvnf_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output pvnf_pkg::pvnf_cfg_t             cfg_o
);

  pvnf_pkg::pvnf_cfg_t cfg_q, cfg_d;
  logic                wr_en;
  logic [1:0]          idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;

  // Update the addressed register on the access phase
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        pvnf_pkg::REG_SALT:  cfg_d.noise_salt   = pwdata;
        pvnf_pkg::REG_BASE:  cfg_d.base_cells   = pwdata[pvnf_pkg::BASE_W-1:0];
        pvnf_pkg::REG_COUNT: cfg_d.octave_count = pwdata[pvnf_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_salt   <= '0;
      cfg_q.base_cells   <= pvnf_pkg::BASE_W'(4);
      cfg_q.octave_count <= pvnf_pkg::COUNT_W'(5);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      pvnf_pkg::REG_SALT:  prdata = cfg_q.noise_salt;
      pvnf_pkg::REG_BASE:  prdata = pvnf_pkg::DATA_W'(cfg_q.base_cells);
      pvnf_pkg::REG_COUNT: prdata = pvnf_pkg::DATA_W'(cfg_q.octave_count);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/pvnf_octave.sv]
// One octave lane: lattice lookup, hashing, fade and bilinear blend, weighting
module pvnf_octave #(
  parameter int OCT = 0,
  parameter int CB  = pvnf_pkg::COORD_BITS_DEF,
  parameter int CW  = pvnf_pkg::BASE_W + pvnf_pkg::MAX_OCTAVES_DEF - 1
) (
  input  logic                                clk_i,
  input  pvnf_pkg::pvnf_cfg_t                 cfg_i,
  input  logic [7:0]                          adv_i,
  input  logic [CB-1:0]                       u_i,
  input  logic [CB-1:0]                       v_i,
  output logic [pvnf_pkg::VAL_W+pvnf_pkg::WGT_W-1:0] wn_o
);

  localparam int GW = CB + CW;
  localparam int VW = pvnf_pkg::VAL_W;
  localparam int TW = CB + 1;
  localparam int LW = VW + TW + 1;
  localparam logic [31:0] SALT_STEP =
    32'(64'(OCT) * 64'(pvnf_pkg::GOLDEN));
  localparam logic [pvnf_pkg::WGT_W-1:0] WEIGHT = pvnf_pkg::octave_weight(OCT);
  localparam logic [TW-1:0] ONE = TW'(1) << CB;
  localparam logic [CB+1:0] THREE_ONE = (CB+2)'(3) << CB;

  // Blend two Q0.24 values with a Q1.CB weight
  function automatic logic [VW-1:0] lerp(logic [VW-1:0] a, logic [VW-1:0] b,
                                         logic [TW-1:0] t);
    logic [LW-1:0] s;
    s = LW'(a) * LW'(ONE - t) + LW'(b) * LW'(t);
    return s[CB+VW-1:CB];
  endfunction

  // Smoothstep second half: f2 * (3 - 2f)
  function automatic logic [TW-1:0] fade2(logic [CB-1:0] f2, logic [CB-1:0] f);
    logic [2*CB+1:0] p;
    p = (2*CB+2)'(f2) * (2*CB+2)'(THREE_ONE - (CB+2)'({f, 1'b0}));
    return p[2*CB:CB];
  endfunction

  logic [CW-1:0] cells;
  logic [31:0]   salt_term_q;

  assign cells = CW'(cfg_i.base_cells) << OCT;

  // Hold the octave salt term, ready well before any item needs it
  always_ff @(posedge clk_i) begin
    salt_term_q <= (cfg_i.noise_salt + SALT_STEP) * pvnf_pkg::GOLDEN + pvnf_pkg::SALT_OFS;
  end

  // Stage 1: scale to the lattice
  logic [GW-1:0] gx_q, gy_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      gx_q <= GW'(u_i) * GW'(cells);
      gy_q <= GW'(v_i) * GW'(cells);
    end
  end

  // Stage 2: wrap corner indexes, square the fractions
  logic [CW-1:0] ix, iy;
  logic [CW:0]   nx, ny;
  logic [CB-1:0] fx, fy;
  logic [2*CB-1:0] fxx, fyy;
  logic [CW-1:0] ix0_q, ix1_q, iy0_q, iy1_q;
  logic [CB-1:0] fx_q, fy_q, fx2_q, fy2_q;

  always_comb begin
    ix  = gx_q[GW-1:CB];
    iy  = gy_q[GW-1:CB];
    nx  = {1'b0, ix} + (CW+1)'(1);
    ny  = {1'b0, iy} + (CW+1)'(1);
    fx  = gx_q[CB-1:0];
    fy  = gy_q[CB-1:0];
    fxx = (2*CB)'(fx) * (2*CB)'(fx);
    fyy = (2*CB)'(fy) * (2*CB)'(fy);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      ix0_q <= (ix >= cells) ? '0 : ix;
      iy0_q <= (iy >= cells) ? '0 : iy;
      ix1_q <= (nx >= {1'b0, cells}) ? '0 : nx[CW-1:0];
      iy1_q <= (ny >= {1'b0, cells}) ? '0 : ny[CW-1:0];
      fx_q  <= fx;
      fy_q  <= fy;
      fx2_q <= fxx[2*CB-1:CB];
      fy2_q <= fyy[2*CB-1:CB];
    end
  end

  // Stage 3: per-axis hash products and fade weights
  logic [31:0]   hx0_q, hx1_q, hy0_q, hy1_q;
  logic [TW-1:0] tx3_q, ty3_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      hx0_q <= 32'(ix0_q) * pvnf_pkg::HASH_X;
      hx1_q <= 32'(ix1_q) * pvnf_pkg::HASH_X;
      hy0_q <= 32'(iy0_q) * pvnf_pkg::HASH_Y;
      hy1_q <= 32'(iy1_q) * pvnf_pkg::HASH_Y;
      tx3_q <= fade2(fx2_q, fx_q);
      ty3_q <= fade2(fy2_q, fy_q);
    end
  end

  // Stage 4: combine axes and salt, first mixer round
  logic [31:0]   h0 [4];
  logic [31:0]   h1_q [4];
  logic [TW-1:0] tx4_q, ty4_q;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h0[c] = (c[0] ? hx1_q : hx0_q) ^ (c[1] ? hy1_q : hy0_q) ^ salt_term_q;
      h0[c] = h0[c] ^ (h0[c] >> 16);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      for (int c = 0; c < 4; c++) h1_q[c] <= h0[c] * pvnf_pkg::MIX_M1;
      tx4_q <= tx3_q;
      ty4_q <= ty3_q;
    end
  end

  // Stage 5: second mixer round
  logic [31:0]   h2_q [4];
  logic [TW-1:0] tx5_q, ty5_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      for (int c = 0; c < 4; c++) h2_q[c] <= (h1_q[c] ^ (h1_q[c] >> 15)) * pvnf_pkg::MIX_M2;
      tx5_q <= tx4_q;
      ty5_q <= ty4_q;
    end
  end

  // Stage 6: corner values, blend along x
  logic [31:0]   hf [4];
  logic [VW-1:0] row0_q, row1_q;
  logic [TW-1:0] ty6_q;
  always_comb begin
    for (int c = 0; c < 4; c++) hf[c] = h2_q[c] ^ (h2_q[c] >> 16);
  end
  always_ff @(posedge clk_i) begin
    if (adv_i[5]) begin
      row0_q <= lerp(hf[0][31:8], hf[1][31:8], tx5_q);
      row1_q <= lerp(hf[2][31:8], hf[3][31:8], tx5_q);
      ty6_q  <= ty5_q;
    end
  end

  // Stage 7: blend along y
  logic [VW-1:0] noise_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[6]) noise_q <= lerp(row0_q, row1_q, ty6_q);
  end

  // Stage 8: apply the octave weight, drop unused octaves
  logic [VW+pvnf_pkg::WGT_W-1:0] wn_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[7]) begin
      wn_q <= (int'(cfg_i.octave_count) > OCT) ?
              (VW+pvnf_pkg::WGT_W)'(noise_q) * (VW+pvnf_pkg::WGT_W)'(WEIGHT) : '0;
    end
  end

  assign wn_o = wn_q;

endmodule

[src/pvnf_sum.sv]
// Registered octave adder tree, normalization and output clamp
module pvnf_sum #(
  parameter int MAX_OCT = pvnf_pkg::MAX_OCTAVES_DEF,
  parameter int TL      = 3,
  parameter int AW      = 52
) (
  input  logic                                        clk_i,
  input  pvnf_pkg::pvnf_cfg_t                         cfg_i,
  input  logic [TL+1:0]                               adv_i,
  input  logic [pvnf_pkg::VAL_W+pvnf_pkg::WGT_W-1:0]  wn_i [MAX_OCT],
  output logic [pvnf_pkg::OUT_W-1:0]                  value_o
);

  localparam int LEAVES = 1 << TL;
  localparam int NW     = AW - 24;
  localparam int PW     = NW + pvnf_pkg::RECIP_W;
  localparam int CNTW   = $clog2(MAX_OCT + 1);

  logic [AW-1:0] leaf [LEAVES];
  logic [AW-1:0] node_q [1:LEAVES-1];

  // Pad the leaves to a power of two
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < MAX_OCT) begin : g_used
      assign leaf[i] = AW'(wn_i[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // One register level of pairwise sums per stage
  for (genvar l = 1; l <= TL; l++) begin : g_lvl
    for (genvar j = 0; j < (LEAVES >> l); j++) begin : g_node
      localparam int N = (LEAVES >> l) + j;
      if (l == 1) begin : g_bot
        always_ff @(posedge clk_i) begin
          if (adv_i[l-1]) node_q[N] <= leaf[2*N-LEAVES] + leaf[2*N+1-LEAVES];
        end
      end else begin : g_up
        always_ff @(posedge clk_i) begin
          if (adv_i[l-1]) node_q[N] <= node_q[2*N] + node_q[2*N+1];
        end
      end
    end
  end

  // Reciprocal of the total weight for each octave count
  logic [pvnf_pkg::RECIP_W-1:0] recip_w [MAX_OCT+1];
  for (genvar c = 0; c <= MAX_OCT; c++) begin : g_recip
    localparam longint unsigned Tot = (c == 0) ? 64'd1 : pvnf_pkg::total_weight(c);
    localparam longint unsigned Rc  = (c == 0) ? 64'd0 : (64'd1 << 40) / Tot;
    assign recip_w[c] = pvnf_pkg::RECIP_W'(Rc);
  end

  logic [4:0]      cnt_full;
  logic [CNTW-1:0] cnt_eff;
  assign cnt_full = {1'b0, cfg_i.octave_count};
  assign cnt_eff  = (cnt_full > 5'(MAX_OCT)) ? CNTW'(MAX_OCT) : CNTW'(cnt_full);

  // Normalize by the total weight
  logic [PW-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[TL]) prod_q <= PW'(node_q[1][AW-1:24]) * PW'(recip_w[cnt_eff]);
  end

  // Clamp to Q0.16
  logic [pvnf_pkg::OUT_W-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[TL+1]) out_q <= (|prod_q[PW-1:40]) ? '1 : prod_q[39:24];
  end

  assign value_o = out_q;

endmodule

[src/periodic_value_noise_fbm_core.sv]
// Top level of the tileable fractal value noise core
//
// Input channel coord (valid/ready) carries a texture coordinate pair in
// unsigned Q0.16; output channel noise (valid/ready) returns one normalized
// noise sample in Q0.16 per coordinate, in order. An APB port sets the salt,
// the base cell count and the octave count; write it only while no item is
// in flight. One transfer is accepted per clock unless every stage is full.
// The core has 8 lane stages plus the adder tree levels (ceil(log2(MAX_OCTAVES)),
// at least one) plus two normalize and clamp stages. Throughput is set by
// the octave lanes, each a fully pipelined chain of single multiplier
// stages, giving one item per cycle unless the receiver stalls. Reset
// clears every valid bit and loads the register reset values. When the
// receiver stalls, each stage holds its item and an empty stage still takes
// the one behind it, so input is refused only once every stage is full.
module periodic_value_noise_fbm_core #(
  parameter int MAX_OCTAVES = pvnf_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_BITS  = pvnf_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             coord_valid_i,
  output logic                             coord_ready_o,
  input  logic [15:0]                      coord_u_i,
  input  logic [15:0]                      coord_v_i,
  output logic                             noise_valid_o,
  input  logic                             noise_ready_i,
  output logic [pvnf_pkg::OUT_W-1:0]       noise_value_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pvnf_pkg::ADDR_W-1:0]      paddr,
  input  logic [pvnf_pkg::DATA_W-1:0]      pwdata,
  output logic [pvnf_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int CW  = pvnf_pkg::BASE_W + MAX_OCTAVES - 1;
  localparam int TL  = (MAX_OCTAVES <= 2) ? 1 : $clog2(MAX_OCTAVES);
  localparam int AW  = pvnf_pkg::VAL_W + pvnf_pkg::WGT_W + $clog2(MAX_OCTAVES + 1);
  localparam int NST = 8 + TL + 2;

  pvnf_pkg::pvnf_cfg_t cfg;

  pvnf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Valid bits and per-stage ready chain
  logic [NST:1] vld_q, vld_d;
  logic [NST:1] rdy;

  always_comb begin
    rdy[NST] = !vld_q[NST] | noise_ready_i;
    for (int s = NST - 1; s >= 1; s--) rdy[s] = !vld_q[s] | rdy[s+1];
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[1]) vld_d[1] = coord_valid_i;
    for (int s = 2; s <= NST; s++) begin
      if (rdy[s]) vld_d[s] = vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign coord_ready_o = rdy[1];
  assign noise_valid_o = vld_q[NST];

  // Octave lanes
  logic [COORD_BITS-1:0] u_c, v_c;
  logic [pvnf_pkg::VAL_W+pvnf_pkg::WGT_W-1:0] wn [MAX_OCTAVES];

  assign u_c = COORD_BITS'(coord_u_i);
  assign v_c = COORD_BITS'(coord_v_i);

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    pvnf_octave #(
      .OCT (k),
      .CB  (COORD_BITS),
      .CW  (CW)
    ) u_oct (
      .clk_i (clk_i),
      .cfg_i (cfg),
      .adv_i (rdy[8:1]),
      .u_i   (u_c),
      .v_i   (v_c),
      .wn_o  (wn[k])
    );
  end

  pvnf_sum #(
    .MAX_OCT (MAX_OCTAVES),
    .TL      (TL),
    .AW      (AW)
  ) u_sum (
    .clk_i   (clk_i),
    .cfg_i   (cfg),
    .adv_i   (rdy[NST:9]),
    .wn_i    (wn),
    .value_o (noise_value_o)
  );

endmodule

[src/pvnf_checker.sv]
// Port-level checker for the noise core, bound to the top level
`include "periodic_value_noise_fbm_core_assert.svh"

module pvnf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        coord_ready_o,
  input logic                        noise_valid_o,
  input logic                        noise_ready_i,
  input logic [pvnf_pkg::OUT_W-1:0]  noise_value_o
);

  // A stalled result stays offered
  `PVNF_ASSERT(a_out_hold, noise_valid_o && !noise_ready_i |=> noise_valid_o, "result dropped while stalled")

  // A stalled result keeps its value
  `PVNF_ASSERT(a_out_stable, noise_valid_o && !noise_ready_i |=> $stable(noise_value_o), "result changed while stalled")

  // Reset empties the pipeline
  `PVNF_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !noise_valid_o, "result offered during reset")

  // An empty output stage lets every stage move, so input is taken
  `PVNF_ASSERT(a_empty_ready, !noise_valid_o |-> coord_ready_o, "input refused with output empty")

endmodule

bind periodic_value_noise_fbm_core pvnf_checker u_pvnf_checker (.*);

[tb/tb_top.sv]
// Testbench for the tileable fractal value noise core
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_OCT = 8;
  localparam int CB = 16;
  localparam int LATENCY = 16;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic coord_valid_i;
  logic coord_ready_o;
  logic [15:0] coord_u_i;
  logic [15:0] coord_v_i;
  logic noise_valid_o;
  logic noise_ready_i;
  logic [pvnf_pkg::OUT_W-1:0] noise_value_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pvnf_pkg::ADDR_W-1:0] paddr;
  logic [pvnf_pkg::DATA_W-1:0] pwdata;
  logic [pvnf_pkg::DATA_W-1:0] prdata;
  logic pready;

  periodic_value_noise_fbm_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .coord_valid_i(coord_valid_i), .coord_ready_o(coord_ready_o),
    .coord_u_i(coord_u_i), .coord_v_i(coord_v_i),
    .noise_valid_o(noise_valid_o), .noise_ready_i(noise_ready_i),
    .noise_value_o(noise_value_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the configuration registers
  logic [31:0] salt_q;
  logic [10:0] cells_q;
  logic [3:0] count_q;

  logic [15:0] noise_fifo[$];
  int errors;
  longint unsigned cycles;
  bit hold_off;       // long receiver stall requested
  bit rand_stall;     // receiver draws random stalls

  // Clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] mix_hash(logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * pvnf_pkg::MIX_M1;
    h = h ^ (h >> 15);
    h = h * pvnf_pkg::MIX_M2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic longint unsigned lattice_val(longint unsigned x, longint unsigned y,
                                                  logic [31:0] salt);
    logic [31:0] h;
    h = 32'(x) * pvnf_pkg::HASH_X;
    h = h ^ (32'(y) * pvnf_pkg::HASH_Y);
    h = h ^ (salt * pvnf_pkg::GOLDEN + pvnf_pkg::SALT_OFS);
    return longint'(mix_hash(h) >> 8);
  endfunction

  function automatic longint unsigned smooth(longint unsigned f);
    longint unsigned sq;
    sq = (f * f) >> CB;
    return (sq * (3 * (64'd1 << CB) - 2 * f)) >> CB;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned t);
    return (a * ((64'd1 << CB) - t) + b * t) >> CB;
  endfunction

  function automatic longint unsigned octave_sample(longint unsigned u, longint unsigned v,
                                                    longint unsigned cells,
                                                    logic [31:0] salt);
    longint unsigned gx, gy, ix, iy, nx, ny, tx, ty, msk;
    msk = (64'd1 << CB) - 1;
    gx = u * cells;
    gy = v * cells;
    ix = gx >> CB;
    iy = gy >> CB;
    nx = ix + 1;
    ny = iy + 1;
    tx = smooth(gx & msk);
    ty = smooth(gy & msk);
    if (nx >= cells) nx = 0;
    if (ny >= cells) ny = 0;
    if (ix >= cells) ix = 0;
    if (iy >= cells) iy = 0;
    return blend(blend(lattice_val(ix, iy, salt), lattice_val(nx, iy, salt), tx),
                 blend(lattice_val(ix, ny, salt), lattice_val(nx, ny, salt), tx), ty);
  endfunction

  // Expected fractal noise for one coordinate pair
  function automatic logic [15:0] fbm_noise(logic [15:0] u, logic [15:0] v);
    int n;
    longint unsigned acc, tot, w, cells, res;
    logic [31:0] salt;
    n = (count_q > MAX_OCT) ? MAX_OCT : count_q;
    if (n == 0) return 16'd0;
    acc = 0;
    tot = 0;
    w = 64'd9395241;
    cells = cells_q;
    for (int k = 0; k < n; k++) begin
      salt = salt_q + 32'(k) * pvnf_pkg::GOLDEN;
      acc += octave_sample(u, v, cells, salt) * w;
      tot += w;
      w = (w * 64'd8053064 + 64'h800000) >> 24;
      cells = cells << 1;
    end
    res = ((acc >> 24) * ((64'd1 << 40) / tot)) >> 24;
    if (res > 64'hffff) res = 64'hffff;
    return 16'(res);
  endfunction

  // Check each result transfer
  always @(posedge clk_i) begin
    if (rst_ni && noise_valid_o && noise_ready_i) begin
      if (noise_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, noise_value_o);
        errors++;
      end else begin
        logic [15:0] exp_val;
        exp_val = noise_fifo.pop_front();
        if (exp_val !== noise_value_o) begin
          $display("%0t: noise mismatch, expected %h, actual %h",
                   $time, exp_val, noise_value_o);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, long hold-off on request
  initial begin
    int gap;
    noise_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        noise_ready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (rand_stall) begin
        gap = $urandom_range(0, 19);
        if (gap == 0) begin
          noise_ready_i <= 1'b1;
        end else begin
          noise_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
          noise_ready_i <= 1'b1;
        end
        @(posedge clk_i);
        while (!noise_valid_o) @(posedge clk_i);
      end else begin
        noise_ready_i <= 1'b1;
      end
    end
  end

  // Register write over the APB port
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pvnf_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pvnf_pkg::REG_SALT: salt_q = val;
      pvnf_pkg::REG_BASE: cells_q = val[10:0];
      pvnf_pkg::REG_COUNT: count_q = val[3:0];
      default: ;
    endcase
  endtask

  // Send one coordinate pair from a falling edge, idle gap drawn unless told otherwise;
  // valid stays up on return so a following item can go out back to back
  task automatic send_coord(logic [15:0] u, logic [15:0] v, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 8 && $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      coord_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    coord_valid_i <= 1'b1;
    coord_u_i <= u;
    coord_v_i <= v;
    @(posedge clk_i);
    while (!coord_ready_o) @(posedge clk_i);
    noise_fifo = {noise_fifo, fbm_noise(u, v)};
    @(negedge clk_i);
  endtask

  // Drop valid and wait for the pipe to drain
  task automatic drain();
    int guard;
    guard = 0;
    coord_valid_i <= 1'b0;
    while (noise_fifo.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_reset_config();
    send_coord(16'h0000, 16'h0000);
    send_coord(16'hffff, 16'hffff);
    send_coord(16'h8000, 16'h4000);
    drain();
  endtask

  // Directed corners: coordinate extremes, zero and capped octaves, zero cells
  task automatic test_directed();
    reg_write(pvnf_pkg::REG_SALT, 32'hffffffff);
    reg_write(pvnf_pkg::REG_BASE, 32'd1);
    reg_write(pvnf_pkg::REG_COUNT, 32'd1);
    send_coord(16'h0000, 16'hffff);
    send_coord(16'hffff, 16'h0000);
    drain();
    reg_write(pvnf_pkg::REG_BASE, 32'd1024);
    reg_write(pvnf_pkg::REG_COUNT, 32'd8);
    send_coord(16'hffff, 16'hffff);
    send_coord(16'h5555, 16'haaaa);
    send_coord(16'h0001, 16'h0001);
    drain();
    reg_write(pvnf_pkg::REG_COUNT, 32'd0);
    send_coord(16'h1234, 16'h5678);
    drain();
    reg_write(pvnf_pkg::REG_COUNT, 32'd15);
    reg_write(pvnf_pkg::REG_BASE, 32'd2047);
    send_coord(16'hfedc, 16'hba98);
    drain();
    reg_write(pvnf_pkg::REG_BASE, 32'd0);
    reg_write(pvnf_pkg::REG_COUNT, 32'd3);
    send_coord(16'h7fff, 16'h8001);
    drain();
  endtask

  // Random coordinates across several register settings
  task automatic test_random();
    for (int ph = 0; ph < 9; ph++) begin
      reg_write(pvnf_pkg::REG_SALT, $urandom());
      reg_write(pvnf_pkg::REG_BASE, (ph % 3 == 0) ? 32'd1024 : $urandom_range(1, 64));
      reg_write(pvnf_pkg::REG_COUNT, (ph == 4) ? 32'd0 : $urandom_range(0, 15));
      for (int i = 0; i < 200; i++) begin
        send_coord(16'($urandom()), 16'($urandom()));
      end
      drain();
    end
  endtask

  // Long receiver stall while items keep coming
  task automatic test_backpressure();
    reg_write(pvnf_pkg::REG_COUNT, 32'd8);
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_coord(16'($urandom()), 16'($urandom()), 1'b1);
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    coord_valid_i = 1'b0;
    coord_u_i = '0;
    coord_v_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    salt_q = 32'd0;
    cells_q = 11'd4;
    count_q = 4'd5;
    errors = 0;
    hold_off = 1'b0;
    rand_stall = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0 && noise_fifo.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
